// ===== design/ctl_pkg.sv =====
package ctl_pkg;

   // Length limit of an identifier or integer token; the length field is 8 bits.
   localparam int MAX_TOKEN_LEN = 255;
   localparam logic [7:0] LEN_LIMIT =
      (MAX_TOKEN_LEN > 255) ? 8'hFF : 8'(MAX_TOKEN_LEN);

   // Depth of the step queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_LPAREN = 3'd0,
      KIND_RPAREN = 3'd1,
      KIND_LBRACE = 3'd2,
      KIND_RBRACE = 3'd3,
      KIND_SEMI   = 3'd4,
      KIND_IDENT  = 3'd5,
      KIND_INT    = 3'd6,
      KIND_ERROR  = 3'd7
   } token_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_IDENT = 2'd1,
      MODE_INT   = 2'd2,
      MODE_HALT  = 2'd3
   } scan_mode_type;

   typedef enum logic [2:0] {
      CLASS_BLANK,
      CLASS_PUNCT,
      CLASS_LETTER,
      CLASS_DIGIT,
      CLASS_OTHER
   } char_class_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_input;
   } req_word_type;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] token_length;
      logic [7:0] offending_byte;
      logic       last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] length;
      logic [7:0] bad;
   } token_type;

   // All tokens caused by one byte: one or two.
   typedef struct packed {
      logic      two;
      token_type first;
      token_type second;
   } step_type;

   typedef struct packed {
      logic     push;
      step_type step;
   } qwrite_type;

   typedef struct packed {
      logic     empty;
      step_type step;
   } qread_type;

   function automatic char_class_type char_class(input logic [7:0] c);
      char_class_type cls;
      if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A)
         cls = CLASS_BLANK;
      else if (c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D || c == 8'h3B)
         cls = CLASS_PUNCT;
      else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
         cls = CLASS_LETTER;
      else if (c >= 8'h30 && c <= 8'h39)
         cls = CLASS_DIGIT;
      else
         cls = CLASS_OTHER;
      return cls;
   endfunction

   function automatic token_kind_type punct_kind(input logic [7:0] c);
      token_kind_type k;
      case (c)
         8'h28: k = KIND_LPAREN;
         8'h29: k = KIND_RPAREN;
         8'h7B: k = KIND_LBRACE;
         8'h7D: k = KIND_RBRACE;
         default: k = KIND_SEMI;
      endcase
      return k;
   endfunction

endpackage

// ===== design/c_token_lexer.sv =====
// A token word is registered in the step queue, whose head drives the rsp_ ports.
// Throughput: one byte per cycle in while req_full is low; one token word per
// cycle out while rsp_pop is high. A byte that closes two tokens stores both in
// one step; the four-entry step queue lets the front keep taking bytes meanwhile.
// Reset (synchronous, active high) clears scan mode, run length and the queue at once.
module c_token_lexer
   import ctl_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = ctl_pkg::MAX_TOKEN_LEN
)
(
   input  logic         clock,
   input  logic         reset,
   // byte input, queue style
   input  logic         req_push,
   output logic         req_full,
   input  req_word_type req_word,
   // token output, queue style
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_word_type rsp_word
);

   // Front end: classify each byte, advance the scan mode and run length, and
   // bundle the one or two tokens that the byte closes into a single step word.
   // Steps that close nothing are dropped here and never reach the queue.
   qwrite_type qwrite;
   qread_type  qread;
   logic       queue_full;
   logic       queue_pop;

   ctl_front #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_word   (req_word),
      .queue_full (queue_full),
      .qwrite     (qwrite)
   );

   // Step queue: decouples the byte rate from the token rate. A byte is taken
   // whenever a slot is free, so full simply mirrors the queue.
   ctl_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .qwrite (qwrite),
      .full   (queue_full),
      .pop    (queue_pop),
      .qread  (qread)
   );

   assign req_full = queue_full;

   // Back end: serve the head step one token per pop, marking the last token
   // of each step, and release the step once its last token is taken.
   ctl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qread     (qread),
      .queue_pop (queue_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== design/ctl_front.sv =====
module ctl_front
   import ctl_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = ctl_pkg::MAX_TOKEN_LEN
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_word_type req_word,
   input  logic         queue_full,
   output qwrite_type   qwrite
);

   // cap the limit at what the 8-bit length field holds
   localparam logic [7:0] LEN_CAP =
      (MAX_TOKEN_LEN > 255) ? 8'hFF : 8'(MAX_TOKEN_LEN);

   scan_mode_type mode_ff, mode_in;
   logic [7:0]    len_ff, len_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
      end
   end

   logic           accept;
   logic           is_open;
   logic [7:0]     ext_len;
   token_type      open_tok;
   token_type      eoi_tok;
   token_type      punct_tok;
   token_type      err_tok;
   token_type [1:0] tok;
   logic [1:0]     cnt;

   assign accept  = req_push && !queue_full;
   assign is_open = (mode_ff == MODE_IDENT) || (mode_ff == MODE_INT);
   assign ext_len = (len_ff < LEN_CAP) ? len_ff + 8'd1 : len_ff;

   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      cnt     = '0;
      tok     = '0;

      open_tok.kind   = (mode_ff == MODE_IDENT) ? KIND_IDENT : KIND_INT;
      open_tok.length = len_ff;
      open_tok.bad    = '0;

      punct_tok.kind   = punct_kind(req_word.char_byte);
      punct_tok.length = 8'd1;
      punct_tok.bad    = '0;

      err_tok.kind   = KIND_ERROR;
      err_tok.length = 8'd1;
      err_tok.bad    = req_word.char_byte;

      eoi_tok = '0;

      if (accept && mode_ff != MODE_HALT) begin
         case (char_class(req_word.char_byte))
            CLASS_BLANK: begin
               if (is_open) begin
                  tok[cnt[0]] = open_tok;
                  cnt = cnt + 2'd1;
               end
               mode_in = MODE_IDLE;
               len_in  = '0;
            end
            CLASS_PUNCT: begin
               if (is_open) begin
                  tok[cnt[0]] = open_tok;
                  cnt = cnt + 2'd1;
               end
               tok[cnt[0]] = punct_tok;
               cnt = cnt + 2'd1;
               mode_in = MODE_IDLE;
               len_in  = '0;
            end
            CLASS_LETTER: begin
               if (mode_ff == MODE_IDENT) begin
                  len_in = ext_len;
               end else begin
                  if (mode_ff == MODE_INT) begin
                     tok[cnt[0]] = open_tok;
                     cnt = cnt + 2'd1;
                  end
                  mode_in = MODE_IDENT;
                  len_in  = 8'd1;
               end
            end
            CLASS_DIGIT: begin
               if (is_open) begin
                  len_in = ext_len;
               end else begin
                  mode_in = MODE_INT;
                  len_in  = 8'd1;
               end
            end
            default: begin
               if (is_open) begin
                  tok[cnt[0]] = open_tok;
                  cnt = cnt + 2'd1;
               end
               tok[cnt[0]] = err_tok;
               cnt = cnt + 2'd1;
               mode_in = MODE_HALT;
               len_in  = '0;
            end
         endcase

         // flush whatever token is still open after this byte
         if (req_word.end_of_input && (mode_in == MODE_IDENT || mode_in == MODE_INT)) begin
            eoi_tok.kind   = (mode_in == MODE_IDENT) ? KIND_IDENT : KIND_INT;
            eoi_tok.length = len_in;
            eoi_tok.bad    = '0;
            tok[cnt[0]] = eoi_tok;
            cnt = cnt + 2'd1;
            mode_in = MODE_IDLE;
            len_in  = '0;
         end
      end
   end

   assign qwrite.push        = (cnt != 2'd0);
   assign qwrite.step.two    = cnt[1];
   assign qwrite.step.first  = tok[0];
   assign qwrite.step.second = tok[1];

endmodule

// ===== design/ctl_queue.sv =====
module ctl_queue
   import ctl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  qwrite_type qwrite,
   output logic       full,
   input  logic       pop,
   output qread_type  qread
);

   step_type [QUEUE_DEPTH-1:0] slot_ff;
   logic [QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]          count_ff, count_in;
   logic                       do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = qwrite.push && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= qwrite.step;
   end

   assign qread.empty = (count_ff == '0);
   assign qread.step  = slot_ff[rd_ptr_ff];

endmodule

// ===== design/ctl_back.sv =====
module ctl_back
   import ctl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  qread_type    qread,
   output logic         queue_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_word_type rsp_word
);

   // which token of the head step is on the result ports
   logic second_ff, second_in;
   logic take;

   assign take      = rsp_pop && !qread.empty;
   assign rsp_empty = qread.empty;

   always_comb begin
      second_in = second_ff;
      queue_pop = 1'b0;
      if (take) begin
         if (!second_ff && qread.step.two) begin
            second_in = 1'b1;
         end else begin
            second_in = 1'b0;
            queue_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         second_ff <= 1'b0;
      else
         second_ff <= second_in;
   end

   token_type cur;
   assign cur = second_ff ? qread.step.second : qread.step.first;

   assign rsp_word.token_kind     = cur.kind;
   assign rsp_word.token_length   = cur.length;
   assign rsp_word.offending_byte = cur.bad;
   assign rsp_word.last_of_run    = second_ff || !qread.step.two;

endmodule

// ===== design/ctl_checker.sv =====
module ctl_checker
   import ctl_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input rsp_word_type rsp_word
);

   // queue comes out of reset empty
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // a waiting word holds until taken
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word)))
      else $error("waiting result word changed or vanished");

   // error halts the lexer: nothing follows the error word
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_word.token_kind == KIND_ERROR) |=> rsp_empty)
      else $error("result word after error token");

   // error word ends its run and has length one
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.token_kind == KIND_ERROR) |->
         (rsp_word.last_of_run && rsp_word.token_length == 8'd1))
      else $error("malformed error token");

   // other words carry no offending byte and a nonzero length
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.token_kind != KIND_ERROR) |->
         (rsp_word.offending_byte == 8'd0 && rsp_word.token_length != 8'd0))
      else $error("malformed token word");

endmodule

bind c_token_lexer ctl_checker u_ctl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_word  (rsp_word)
);
